FILE: src/mls_pkg.sv
// Package for the motor lifecycle supervisor: codes, fault bit positions and the
// structs passed between the step logic and the top level. No dependencies.
package mls_pkg;

  localparam int unsigned CntW = 16;
  localparam logic [CntW-1:0] CalTimeoutReset = 16'd2000;
  localparam logic [CntW-1:0] CntMax = 16'hFFFF;

  // Event codes carried by the action field
  typedef enum logic [2:0] {
    ACT_TICK     = 3'd0,
    ACT_START    = 3'd1,
    ACT_STOP     = 3'd2,
    ACT_CAL_REQ  = 3'd3,
    ACT_CLEAR    = 3'd4,
    ACT_BG_CHECK = 3'd5
  } action_e;

  typedef enum logic [2:0] {
    LC_INIT  = 3'd0,
    LC_CAL   = 3'd1,
    LC_IDLE  = 3'd2,
    LC_RUN   = 3'd3,
    LC_FAULT = 3'd4
  } lc_state_e;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_START = 2'd1,
    CMD_STOP  = 2'd2,
    CMD_CAL   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BUSY    = 2'd1,
    ST_INVALID = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CAL_BUSY     = 2'd0,
    CAL_COMPLETE = 2'd1
  } cal_status_e;

  localparam logic [1:0] ModeMax = 2'd2;

  // Fault bit positions
  localparam int unsigned FTimeout  = 0;
  localparam int unsigned FCal      = 1;
  localparam int unsigned FCommit   = 2;
  localparam int unsigned FEnable   = 3;
  localparam int unsigned FPosition = 4;
  localparam int unsigned FSample   = 5;
  localparam int unsigned FMath     = 6;
  localparam int unsigned FState    = 7;

  typedef struct packed {
    action_e    action;
    logic [1:0] mode;
    logic [1:0] cal_status;
    logic       sample_ok;
    logic       position_ok;
    logic       math_ok;
    logic       commit_ok;
    logic       enable_ok;
  } mls_item_t;

  typedef struct packed {
    lc_state_e       lc;
    logic [7:0]      faults;
    logic            pwm;
    logic            calibrated;
    logic            start_after_cal;
    cmd_e            pending;
    logic [CntW-1:0] cal_cnt;
    logic [1:0]      mode;
  } mls_state_t;

  typedef struct packed {
    status_e    status;
    lc_state_e  lc;
    logic [7:0] faults;
    logic       pwm_on;
    logic       calibrated;
    logic [1:0] active_mode;
    logic       cal_begin;
    logic       control_ran;
    logic       activated;
    logic       estop;
  } mls_result_t;

endpackage

FILE: src/mls_step.sv
// Combinational event step of the motor lifecycle supervisor: next state and
// the result for one event. Depends on mls_pkg.
module mls_step import mls_pkg::*; (
  input  mls_item_t       item_i,
  input  mls_state_t      state_i,
  input  logic [CntW-1:0] timeout_i,
  output mls_state_t      state_o,
  output mls_result_t     result_o
);

  status_e         status;
  logic            p_calbegin, p_control, p_act, p_stop;
  logic            fault_hit;
  logic [7:0]      fault_bit;
  logic [CntW-1:0] cnt_inc;
  mls_state_t      nxt;

  assign cnt_inc = (state_i.cal_cnt != CntMax) ? state_i.cal_cnt + 16'd1 : state_i.cal_cnt;

  // Next state and pulses; a fault is the last thing any path does, so it is
  // applied once at the end
  always_comb begin
    nxt        = state_i;
    status     = ST_OK;
    p_calbegin = 1'b0;
    p_control  = 1'b0;
    p_act      = 1'b0;
    p_stop     = 1'b0;
    fault_hit  = 1'b0;
    fault_bit  = '0;

    unique case (item_i.action)
      ACT_TICK: begin
        nxt.pending = CMD_NONE;
        unique case (state_i.pending)
          CMD_START: begin
            if (state_i.lc == LC_IDLE && state_i.faults == '0 && state_i.calibrated) begin
              p_act = 1'b1;
              if (!item_i.commit_ok) begin
                fault_hit = 1'b1; fault_bit[FCommit] = 1'b1;
              end else if (!item_i.enable_ok) begin
                fault_hit = 1'b1; fault_bit[FEnable] = 1'b1;
              end else begin
                nxt.pwm = 1'b1;
                nxt.lc  = LC_RUN;
              end
            end else if (state_i.lc == LC_INIT && state_i.faults == '0) begin
              nxt.start_after_cal = 1'b1;
              p_calbegin  = 1'b1;
              nxt.cal_cnt = '0;
              nxt.lc      = LC_CAL;
            end else if (state_i.lc == LC_CAL && state_i.faults == '0) begin
              nxt.start_after_cal = 1'b1;
            end
          end
          CMD_STOP: begin
            p_stop  = 1'b1;
            nxt.pwm = 1'b0;
            nxt.lc  = (state_i.faults == '0) ? LC_IDLE : LC_FAULT;
          end
          CMD_CAL: begin
            if (state_i.lc == LC_IDLE && state_i.faults == '0) begin
              nxt.start_after_cal = 1'b0;
              p_calbegin  = 1'b1;
              nxt.cal_cnt = '0;
              nxt.lc      = LC_CAL;
            end
          end
          default: begin
            // No pending command: regular lifecycle step
            unique case (state_i.lc)
              LC_INIT: begin
                p_calbegin  = 1'b1;
                nxt.cal_cnt = '0;
                nxt.lc      = LC_CAL;
              end
              LC_CAL: begin
                nxt.cal_cnt = cnt_inc;
                if (item_i.cal_status == CAL_BUSY) begin
                  if (cnt_inc >= timeout_i) begin
                    fault_hit = 1'b1; fault_bit[FTimeout] = 1'b1;
                  end
                end else if (item_i.cal_status != CAL_COMPLETE) begin
                  fault_hit = 1'b1; fault_bit[FCal] = 1'b1;
                end else begin
                  nxt.calibrated = 1'b1;
                  nxt.lc         = LC_IDLE;
                  if (state_i.start_after_cal) begin
                    nxt.start_after_cal = 1'b0;
                    p_act = 1'b1;
                    if (!item_i.commit_ok) begin
                      fault_hit = 1'b1; fault_bit[FCommit] = 1'b1;
                    end else if (!item_i.enable_ok) begin
                      fault_hit = 1'b1; fault_bit[FEnable] = 1'b1;
                    end else begin
                      nxt.pwm = 1'b1;
                      nxt.lc  = LC_RUN;
                    end
                  end
                end
              end
              LC_RUN: begin
                p_control = 1'b1;
                if (!item_i.sample_ok) begin
                  fault_hit = 1'b1; fault_bit[FSample] = 1'b1;
                end else if (!item_i.position_ok) begin
                  fault_hit = 1'b1; fault_bit[FPosition] = 1'b1;
                end else if (!item_i.math_ok) begin
                  fault_hit = 1'b1; fault_bit[FMath] = 1'b1;
                end else if (!item_i.commit_ok) begin
                  fault_hit = 1'b1; fault_bit[FCommit] = 1'b1;
                end
              end
              LC_IDLE, LC_FAULT: begin
              end
              default: begin
                fault_hit = 1'b1; fault_bit[FState] = 1'b1;
              end
            endcase
          end
        endcase
      end
      ACT_START: begin
        if (item_i.mode > ModeMax) begin
          status = ST_INVALID;
        end else if ((state_i.lc != LC_IDLE && state_i.lc != LC_INIT &&
                      state_i.lc != LC_CAL) || state_i.faults != '0) begin
          status = ST_BUSY;
        end else begin
          nxt.mode = item_i.mode;
          if (state_i.lc == LC_INIT) begin
            nxt.start_after_cal = 1'b1;
            p_calbegin  = 1'b1;
            nxt.cal_cnt = '0;
            nxt.lc      = LC_CAL;
          end else if (state_i.lc == LC_CAL) begin
            nxt.start_after_cal = 1'b1;
          end else begin
            nxt.pending = CMD_START;
          end
        end
      end
      ACT_STOP: begin
        p_stop      = 1'b1;
        nxt.pwm     = 1'b0;
        nxt.pending = CMD_NONE;
        nxt.lc      = (state_i.faults == '0) ? LC_IDLE : LC_FAULT;
      end
      ACT_CAL_REQ: begin
        if (state_i.lc != LC_IDLE || state_i.faults != '0) begin
          status = ST_BUSY;
        end else begin
          nxt.pending = CMD_CAL;
        end
      end
      ACT_CLEAR: begin
        if (state_i.lc != LC_FAULT || state_i.pwm) begin
          status = ST_BUSY;
        end else begin
          nxt.faults = '0;
          nxt.lc     = LC_IDLE;
        end
      end
      ACT_BG_CHECK: begin
        if (!item_i.position_ok) begin
          fault_hit = 1'b1; fault_bit[FPosition] = 1'b1;
        end
      end
      default: begin
        status = ST_INVALID;
      end
    endcase

    // Fault entry: emergency stop, PWM off, latch the bit
    if (fault_hit) begin
      p_stop     = 1'b1;
      nxt.pwm    = 1'b0;
      nxt.faults = nxt.faults | fault_bit;
      nxt.lc     = LC_FAULT;
    end
  end

  assign state_o = nxt;

  // Result assembly from the post-event state
  always_comb begin
    result_o.status      = status;
    result_o.lc          = nxt.lc;
    result_o.faults      = nxt.faults;
    result_o.pwm_on      = nxt.pwm;
    result_o.calibrated  = nxt.calibrated;
    result_o.active_mode = nxt.mode;
    result_o.cal_begin   = p_calbegin;
    result_o.control_ran = p_control;
    result_o.activated   = p_act;
    result_o.estop       = p_stop;
  end

endmodule

FILE: src/motor_lifecycle_supervisor_top.sv
// Top level of the motor lifecycle supervisor: input register, state and
// configuration registers, result register. Depends on mls_pkg and mls_step.

// One event in, one result out. An event is transferred into an input register,
// processed combinationally by the step logic against the lifecycle state, and
// the result is held in an output register until transferred; a new event can be
// taken every cycle while the output does not stall, so throughput is one event
// per clock. The result is loaded into the output register when the held event
// advances; a stalled output holds the input register, which then deasserts
// in_ready_o. The calibration timeout register is written with cfg_we_i and
// should only change while no event is in flight.
module motor_lifecycle_supervisor_top import mls_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  action_i,
  input  logic [1:0]  mode_i,
  input  logic [1:0]  cal_status_i,
  input  logic        sample_ok_i,
  input  logic        position_ok_i,
  input  logic        math_ok_i,
  input  logic        commit_ok_i,
  input  logic        enable_ok_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [2:0]  lifecycle_o,
  output logic [7:0]  fault_bits_o,
  output logic        pwm_on_o,
  output logic        is_calibrated_o,
  output logic [1:0]  active_mode_o,
  output logic        calibration_begin_o,
  output logic        control_ran_o,
  output logic        activated_o,
  output logic        emergency_stop_o
);

  logic            in_valid_q, out_valid_q, advance;
  mls_item_t       item_q;
  mls_state_t      state_q, state_d;
  mls_result_t     res_q, res_d;
  logic [CntW-1:0] timeout_q;

  // An event is processed when the output register is free or being drained
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= CalTimeoutReset;
    end else if (cfg_we_i) begin
      timeout_q <= cfg_wdata_i;
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.action      <= action_e'(action_i);
      item_q.mode        <= mode_i;
      item_q.cal_status  <= cal_status_i;
      item_q.sample_ok   <= sample_ok_i;
      item_q.position_ok <= position_ok_i;
      item_q.math_ok     <= math_ok_i;
      item_q.commit_ok   <= commit_ok_i;
      item_q.enable_ok   <= enable_ok_i;
    end
  end

  mls_step u_step (
    .item_i   (item_q),
    .state_i  (state_q),
    .timeout_i(timeout_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  // Lifecycle state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.lc              <= LC_INIT;
      state_q.faults          <= '0;
      state_q.pwm             <= 1'b0;
      state_q.calibrated      <= 1'b0;
      state_q.start_after_cal <= 1'b0;
      state_q.pending         <= CMD_NONE;
      state_q.cal_cnt         <= '0;
      state_q.mode            <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign status_o            = res_q.status;
  assign lifecycle_o         = res_q.lc;
  assign fault_bits_o        = res_q.faults;
  assign pwm_on_o            = res_q.pwm_on;
  assign is_calibrated_o     = res_q.calibrated;
  assign active_mode_o       = res_q.active_mode;
  assign calibration_begin_o = res_q.cal_begin;
  assign control_ran_o       = res_q.control_ran;
  assign activated_o         = res_q.activated;
  assign emergency_stop_o    = res_q.estop;

  // PWM is only on while running
  a_pwm_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.pwm |-> state_q.lc == LC_RUN)
    else $error("PWM enabled outside running state");

  // An emergency stop always leaves PWM off
  a_estop_pwm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.estop |-> !res_q.pwm_on)
    else $error("emergency stop with PWM still on");

  // A held event is not lost while the output stalls
  a_hold_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q)
    else $error("pending event dropped");

  // Every processed event produces a result
  a_result_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("processed event without result");

endmodule
